// ----- rtl/crcv_pkg.sv -----
// Package: shared types and constants of the closed Catmull-Rom curve evaluator.
`timescale 1ns / 1ps
package crcv_pkg;

  localparam int MAX_POINTS_DEF  = 64;
  localparam int COORD_BITS_DEF  = 32;
  localparam logic [6:0] POINT_COUNT_RST = 7'd4;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_EVAL = 1'b1;

  typedef struct packed {
    logic               func;
    logic [5:0]         point_index;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
    logic [15:0]        curve_param;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] slope_x;
    logic signed [31:0] slope_y;
    logic signed [31:0] slope_z;
  } out_item_t;

endpackage

// ----- rtl/crcv_axis.sv -----
// Per-axis Catmull-Rom polynomial and tangent pipeline, seven register stages.
`timescale 1ns / 1ps
module crcv_axis #(
  parameter int CW = 32
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [CW-1:0] p0,
  input  logic signed [CW-1:0] p1,
  input  logic signed [CW-1:0] p2,
  input  logic signed [CW-1:0] p3,
  input  logic [15:0]          f,
  output logic signed [31:0]   pos,
  output logic signed [31:0]   slope
);

  localparam int HW = CW + 7;
  localparam int MW = HW + 17;
  localparam logic signed [HW:0] SAT_HI = (HW+1)'((64'sd1 <<< (CW-1)) - 64'sd1);
  localparam logic signed [HW:0] SAT_LO = -SAT_HI - (HW+1)'(1);

  // coefficient stage
  logic signed [HW-1:0] a0_c_r, a0t_c_r, a1_c_r, a2_c_r, a3_c_r;
  logic [15:0]          f_c_r;
  logic signed [HW-1:0] a0_nxt, a1_nxt, a2_nxt, a3_nxt;
  // first multiply
  logic signed [MW-1:0] mh_m1_r, mg_m1_r;
  logic signed [HW-1:0] a1_m1_r, a2_m1_r, a3_m1_r;
  logic [15:0]          f_m1_r;
  // first round/add
  logic signed [HW-1:0] h_r1_r, g_r1_r, a2_r1_r, a3_r1_r;
  logic [15:0]          f_r1_r;
  logic signed [MW-1:0] rh1_sum, rg1_sum;
  // second multiply
  logic signed [MW-1:0] mh_m2_r, mg_m2_r;
  logic signed [HW-1:0] a2_m2_r, a3_m2_r;
  logic [15:0]          f_m2_r;
  // second round/add, tangent finish
  logic signed [HW-1:0] h_r2_r, a3_r2_r;
  logic [15:0]          f_r2_r;
  logic signed [31:0]   slope_r2_r;
  logic signed [MW-1:0] rh2_sum, rg2_sum;
  logic signed [HW-1:0] g2;
  logic signed [HW:0]   g_half;
  logic signed [CW-1:0] slope_sat;
  // third multiply
  logic signed [MW-1:0] mh_m3_r;
  logic signed [HW-1:0] a3_m3_r;
  logic signed [31:0]   slope_m3_r;
  // output
  logic signed [MW-1:0] rh3_sum;
  logic signed [HW-1:0] h3;
  logic signed [HW:0]   h_half;
  logic signed [CW-1:0] pos_sat;
  logic signed [31:0]   pos_r, slope_r;

  always_comb begin
    a0_nxt = -HW'(p0) + 3 * HW'(p1) - 3 * HW'(p2) + HW'(p3);
    a1_nxt = 2 * HW'(p0) - 5 * HW'(p1) + 4 * HW'(p2) - HW'(p3);
    a2_nxt = HW'(p2) - HW'(p0);
    a3_nxt = 2 * HW'(p1);
  end

  // round to nearest, ties up: (x + 2^15) >>> 16
  always_comb begin
    rh1_sum = mh_m1_r + MW'(32768);
    rg1_sum = mg_m1_r + MW'(32768);
    rh2_sum = mh_m2_r + MW'(32768);
    rg2_sum = mg_m2_r + MW'(32768);
    rh3_sum = mh_m3_r + MW'(32768);
  end

  always_comb begin
    g2     = $signed(rg2_sum[HW+15:16]) + a2_m2_r;
    g_half = $signed({g2[HW-1], g2} + (HW+1)'(1)) >>> 1;
    if (g_half > SAT_HI) begin
      slope_sat = CW'(SAT_HI);
    end else if (g_half < SAT_LO) begin
      slope_sat = CW'(SAT_LO);
    end else begin
      slope_sat = CW'(g_half);
    end
  end

  always_comb begin
    h3     = $signed(rh3_sum[HW+15:16]) + a3_m3_r;
    h_half = $signed({h3[HW-1], h3} + (HW+1)'(1)) >>> 1;
    if (h_half > SAT_HI) begin
      pos_sat = CW'(SAT_HI);
    end else if (h_half < SAT_LO) begin
      pos_sat = CW'(SAT_LO);
    end else begin
      pos_sat = CW'(h_half);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a0_c_r     <= a0_nxt;
      a0t_c_r    <= 3 * a0_nxt;
      a1_c_r     <= a1_nxt;
      a2_c_r     <= a2_nxt;
      a3_c_r     <= a3_nxt;
      f_c_r      <= f;

      mh_m1_r    <= a0_c_r * $signed({1'b0, f_c_r});
      mg_m1_r    <= a0t_c_r * $signed({1'b0, f_c_r});
      a1_m1_r    <= a1_c_r;
      a2_m1_r    <= a2_c_r;
      a3_m1_r    <= a3_c_r;
      f_m1_r     <= f_c_r;

      h_r1_r     <= $signed(rh1_sum[HW+15:16]) + a1_m1_r;
      g_r1_r     <= $signed(rg1_sum[HW+15:16]) + (a1_m1_r <<< 1);
      a2_r1_r    <= a2_m1_r;
      a3_r1_r    <= a3_m1_r;
      f_r1_r     <= f_m1_r;

      mh_m2_r    <= h_r1_r * $signed({1'b0, f_r1_r});
      mg_m2_r    <= g_r1_r * $signed({1'b0, f_r1_r});
      a2_m2_r    <= a2_r1_r;
      a3_m2_r    <= a3_r1_r;
      f_m2_r     <= f_r1_r;

      h_r2_r     <= $signed(rh2_sum[HW+15:16]) + a2_m2_r;
      slope_r2_r <= 32'(slope_sat);
      a3_r2_r    <= a3_m2_r;
      f_r2_r     <= f_m2_r;

      mh_m3_r    <= h_r2_r * $signed({1'b0, f_r2_r});
      a3_m3_r    <= a3_r2_r;
      slope_m3_r <= slope_r2_r;

      pos_r      <= 32'(pos_sat);
      slope_r    <= slope_m3_r;
    end
  end

  assign pos   = pos_r;
  assign slope = slope_r;

endmodule

// ----- rtl/catmull_rom_closed_curve_eval_unit.sv -----
// Top level of the closed uniform Catmull-Rom curve evaluator.
`timescale 1ns / 1ps
// Takes one item per cycle, loads and evaluates alike, and keeps that rate as
// long as the result side takes results. An evaluate result passes through
// one input stage that scales the parameter by the point count, one stage
// that reads the four neighbor points from the point store, and seven
// arithmetic stages per axis (coefficients, then three multiply/round-add
// pairs, the last one feeding the output register). A load is registered in
// the input stage, writes its slot when the pipeline next advances and gives
// no result. The whole pipeline advances together and holds while a result
// waits. point_count may be rewritten only while no item is in flight. Slots
// read by an evaluate must have been loaded before.
module catmull_rom_closed_curve_eval_unit #(
  parameter int MAX_POINTS = crcv_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = crcv_pkg::COORD_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  crcv_pkg::in_item_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output crcv_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [6:0]         cfg_data
);

  localparam int CW   = (COORD_BITS < 32) ? COORD_BITS : 32;
  localparam int AW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int NW   = $clog2(MAX_POINTS + 1);
  localparam int CMPW = (NW > 7) ? NW : 7;
  localparam int IW   = (NW > 6) ? NW : 6;
  localparam int WW   = 3 * CW;
  localparam int AXS  = 7;

  logic             advance;
  logic [6:0]       point_count_r;
  logic [NW-1:0]    n_eff;
  logic [NW+15:0]   s_prod;

  // stage A: accepted item
  logic             a_vld_r;
  logic             a_func_r;
  logic [5:0]       a_idx_r;
  logic [WW-1:0]    a_word_r;
  logic [AW-1:0]    a_seg_r;
  logic [15:0]      a_f_r;
  logic [NW-1:0]    a_n_r;
  logic [AW-1:0]    i0, i2, i3;
  logic [NW:0]      seg_p1, seg_p2;
  logic             a_wr;

  // stage B: points read
  logic             b_vld_r;
  logic [WW-1:0]    b_p0_r, b_p1_r, b_p2_r, b_p3_r;
  logic [15:0]      b_f_r;

  logic [WW-1:0]    mem_a [MAX_POINTS];
  logic [WW-1:0]    mem_b [MAX_POINTS];

  logic [AXS-1:0]   v_r;
  logic signed [31:0] pos_v [3];
  logic signed [31:0] slope_v [3];

  assign advance   = !out_valid || out_ready;
  assign in_ready  = advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_count_r <= crcv_pkg::POINT_COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      point_count_r <= cfg_data;
    end
  end

  // count zero acts as one, above the store depth it saturates
  always_comb begin
    if (point_count_r == 7'd0) begin
      n_eff = NW'(1);
    end else if (CMPW'(point_count_r) > CMPW'(MAX_POINTS)) begin
      n_eff = NW'(MAX_POINTS);
    end else begin
      n_eff = NW'(point_count_r);
    end
    s_prod = in_data.curve_param * n_eff;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (advance) begin
      a_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      a_func_r <= in_data.func;
      a_idx_r  <= in_data.point_index;
      a_word_r <= {in_data.coord_z[CW-1:0], in_data.coord_y[CW-1:0],
                   in_data.coord_x[CW-1:0]};
      a_seg_r  <= AW'(s_prod[NW+15:16]);
      a_f_r    <= s_prod[15:0];
      a_n_r    <= n_eff;
    end
  end

  // neighbor slots with wraparound; segment is always below the count
  always_comb begin
    seg_p1 = (NW+1)'(a_seg_r) + (NW+1)'(1);
    seg_p2 = (NW+1)'(a_seg_r) + (NW+1)'(2);
    if (a_seg_r == AW'(0)) begin
      i0 = AW'(a_n_r - NW'(1));
    end else begin
      i0 = a_seg_r - AW'(1);
    end
    if (seg_p1 == (NW+1)'(a_n_r)) begin
      i2 = AW'(0);
    end else begin
      i2 = AW'(seg_p1);
    end
    if (a_n_r == NW'(1)) begin
      i3 = AW'(0);
    end else if (seg_p2 >= (NW+1)'(a_n_r)) begin
      i3 = AW'(seg_p2 - (NW+1)'(a_n_r));
    end else begin
      i3 = AW'(seg_p2);
    end
  end

  // out-of-range load slots are dropped
  assign a_wr = advance && a_vld_r && (a_func_r == crcv_pkg::FUNC_LOAD) &&
                (IW'(a_idx_r) < IW'(MAX_POINTS));

  // two copies of the store give four read ports
  always_ff @(posedge clk) begin
    if (a_wr) begin
      mem_a[AW'(a_idx_r)] <= a_word_r;
      mem_b[AW'(a_idx_r)] <= a_word_r;
    end
    if (advance) begin
      b_p0_r <= mem_a[i0];
      b_p1_r <= mem_a[a_seg_r];
      b_p2_r <= mem_b[i2];
      b_p3_r <= mem_b[i3];
      b_f_r  <= a_f_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
      v_r     <= '0;
    end else if (advance) begin
      b_vld_r <= a_vld_r && (a_func_r == crcv_pkg::FUNC_EVAL);
      v_r     <= {v_r[AXS-2:0], b_vld_r};
    end
  end

  for (genvar ax = 0; ax < 3; ax++) begin : g_axis
    crcv_axis #(.CW(CW)) u_axis (
      .clk   (clk),
      .en    (advance),
      .p0    ($signed(b_p0_r[ax*CW +: CW])),
      .p1    ($signed(b_p1_r[ax*CW +: CW])),
      .p2    ($signed(b_p2_r[ax*CW +: CW])),
      .p3    ($signed(b_p3_r[ax*CW +: CW])),
      .f     (b_f_r),
      .pos   (pos_v[ax]),
      .slope (slope_v[ax])
    );
  end

  assign out_valid        = v_r[AXS-1];
  assign out_data.pos_x   = pos_v[0];
  assign out_data.pos_y   = pos_v[1];
  assign out_data.pos_z   = pos_v[2];
  assign out_data.slope_x = slope_v[0];
  assign out_data.slope_y = slope_v[1];
  assign out_data.slope_z = slope_v[2];

endmodule

// ----- rtl/crcv_chk.sv -----
// Port-level checker for the curve evaluator, bound to the top level.
`timescale 1ns / 1ps
module crcv_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input crcv_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input crcv_pkg::out_item_t out_data,
  input logic                cfg_valid,
  input logic                cfg_ready,
  input logic [6:0]          cfg_data
);

  // a waiting result stays
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a waiting result keeps its value
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("stalled result changed");

  // input is refused only while a result waits
  a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a waiting result");

  // the register port never blocks
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("configuration write refused");

endmodule

bind catmull_rom_closed_curve_eval_unit crcv_chk u_crcv_chk (.*);
